/* design/lgti_pkg.sv */
// Shared types, codes and helpers for the LDA Gibbs topic inference block.
package lgti_pkg;

  localparam int NUM_TOPICS_DEF    = 16;
  localparam int VOCAB_SIZE_DEF    = 1024;
  localparam int MAX_DOC_WORDS_DEF = 256;

  localparam logic [15:0] ALPHA_RST  = 16'd26;
  localparam logic [31:0] SEED_RST   = 32'd1;
  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_SEED  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_APPEND = 2'd1,
    OP_RUN    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_APPEND,
    CMD_START,
    CMD_READ,
    CMD_REMOVE,
    CMD_PHI,
    CMD_MUL,
    CMD_ACC,
    CMD_DRAW_LO,
    CMD_DRAW_HI,
    CMD_DRAW_U,
    CMD_SRD,
    CMD_SCMP,
    CMD_COMMIT,
    CMD_OUT_INIT,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_OUT_NEXT,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_REMOVE,
    S_PHI,
    S_MUL,
    S_ACC,
    S_DRAW_LO,
    S_DRAW_HI,
    S_DRAW_U,
    S_SRD,
    S_SCMP,
    S_COMMIT,
    S_OUT_INIT,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic run_empty;
    logic k_last;
    logic n_last;
    logic s_last;
    logic total_zero;
    logic hit;
    logic div_done;
  } sts_t;

  // Galois LFSR, one shift per draw
  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    logic [31:0] t;
    t = s >> 1;
    if (s[0]) t = t ^ LFSR_TAPS;
    return t;
  endfunction

endpackage

/* design/lgti_ctrl.sv */
// Controller state machine: sequences loads, Gibbs sweeps and result output.
module lgti_ctrl
  import lgti_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_IDLE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(in_op))
            OP_LOAD:   cmd = CMD_LOAD;
            OP_APPEND: cmd = CMD_APPEND;
            OP_RUN: begin
              cmd       = CMD_START;
              state_nxt = S_CHECK;
            end
            default:   cmd = CMD_IDLE;
          endcase
        end
      end
      S_CHECK:    state_nxt = sts.run_empty ? S_OUT_INIT : S_READ;
      S_READ: begin
        cmd       = CMD_READ;
        state_nxt = S_REMOVE;
      end
      S_REMOVE: begin
        cmd       = CMD_REMOVE;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd       = CMD_PHI;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd       = CMD_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd       = CMD_ACC;
        state_nxt = sts.k_last ? S_DRAW_LO : S_PHI;
      end
      S_DRAW_LO: begin
        cmd       = CMD_DRAW_LO;
        state_nxt = S_DRAW_HI;
      end
      S_DRAW_HI: begin
        cmd       = CMD_DRAW_HI;
        state_nxt = S_DRAW_U;
      end
      S_DRAW_U: begin
        cmd       = CMD_DRAW_U;
        // zero total: keep the old topic
        state_nxt = sts.total_zero ? S_COMMIT : S_SRD;
      end
      S_SRD: begin
        cmd       = CMD_SRD;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd       = CMD_SCMP;
        state_nxt = (sts.hit || sts.k_last) ? S_COMMIT : S_SRD;
      end
      S_COMMIT: begin
        cmd       = CMD_COMMIT;
        state_nxt = (sts.n_last && sts.s_last) ? S_OUT_INIT : S_READ;
      end
      S_OUT_INIT: begin
        cmd       = CMD_OUT_INIT;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd       = CMD_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd       = CMD_DIV_STEP;
        state_nxt = sts.div_done ? S_OUT : S_DIV;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.k_last) begin
            cmd       = CMD_CLEAR;
            state_nxt = S_IDLE;
          end else begin
            cmd       = CMD_OUT_NEXT;
            state_nxt = S_DIV_INIT;
          end
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

endmodule

/* design/lgti_dp.sv */
// Datapath: stores, topic counters, weight accumulator, draw scaling and divider.
module lgti_dp
  import lgti_pkg::*;
#(
  parameter int NUM_TOPICS    = NUM_TOPICS_DEF,
  parameter int VOCAB_SIZE    = VOCAB_SIZE_DEF,
  parameter int MAX_DOC_WORDS = MAX_DOC_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [3:0]  in_topic_index,
  input  logic [9:0]  in_term_id,
  input  logic [15:0] in_term_prob,
  input  logic [9:0]  in_sweep_count,
  output logic [3:0]  out_topic,
  output logic [16:0] out_theta_q0_16,
  output logic        out_last
);

  localparam int TW  = $clog2(NUM_TOPICS);
  localparam int NW  = (MAX_DOC_WORDS > 1) ? $clog2(MAX_DOC_WORDS) : 1;
  localparam int CW  = $clog2(MAX_DOC_WORDS + 1);
  localparam int PA  = $clog2(NUM_TOPICS * VOCAB_SIZE);
  localparam int AW  = ((CW + 8 > 16) ? CW + 8 : 16) + 1;
  localparam int WW  = AW + 16;
  localparam int SW  = WW + TW;
  localparam int DW  = ((CW + 8 > TW + 16) ? CW + 8 : TW + 16) + 1;
  localparam int RW  = DW + 1;
  localparam logic [PA-1:0] VOC   = PA'(VOCAB_SIZE);
  localparam logic [TW-1:0] K_TOP = TW'(NUM_TOPICS - 1);

  logic [15:0]    phi_mem  [NUM_TOPICS * VOCAB_SIZE];
  logic [9:0]     word_mem [MAX_DOC_WORDS];
  logic [TW-1:0]  asg_mem  [MAX_DOC_WORDS];
  logic [SW-1:0]  wsum_mem [NUM_TOPICS];

  logic [CW-1:0]  cnt_r [NUM_TOPICS];
  logic [CW-1:0]  doc_len_r;
  logic [15:0]    alpha_r;
  logic [31:0]    lfsr_r;
  logic [9:0]     sweeps_r, s_r;
  logic [NW-1:0]  n_r;
  logic [TW-1:0]  k_r, pick_r, asg_q_r;
  logic [9:0]     term_r, word_q_r;
  logic           term_ok_r;
  logic [15:0]    phi_q_r;
  logic [WW-1:0]  w_r;
  logic [SW-1:0]  total_r, ws_q_r, u_r, hi_prod_r;
  logic [31:0]    r_r;
  logic [63:0]    lo_prod_r;
  logic [RW-1:0]  rem_r;
  logic [16:0]    q_r;
  logic [4:0]     bit_r;

  logic [31:0]    lfsr_adv;
  logic [TW-1:0]  app_topic;
  logic [CW-1:0]  cnt_k;
  logic [AW-1:0]  aval;
  logic [SW-1:0]  tsum;
  logic [DW-1:0]  den;
  logic [RW-1:0]  rem_sub;
  logic           ge;
  logic [PA-1:0]  phi_addr;
  logic           load_ok;

  assign lfsr_adv  = lfsr_next(lfsr_r);
  assign app_topic = TW'((32'(lfsr_adv[31:16]) * 32'(NUM_TOPICS)) >> 16);
  assign cnt_k     = cnt_r[k_r];
  assign aval      = AW'({cnt_k, 8'd0}) + AW'(alpha_r);
  assign tsum      = total_r + SW'(w_r);
  assign den       = DW'({doc_len_r, 8'd0}) + DW'(NUM_TOPICS) * DW'(alpha_r);
  assign ge        = (rem_r >= RW'(den));
  assign rem_sub   = ge ? (rem_r - RW'(den)) : rem_r;
  assign phi_addr  = PA'(k_r) * VOC + PA'(term_r);
  assign load_ok   = (32'(in_topic_index) < NUM_TOPICS) && (32'(in_term_id) < VOCAB_SIZE);

  assign sts.run_empty  = (sweeps_r == '0) || (doc_len_r == '0);
  assign sts.k_last     = (k_r == K_TOP);
  assign sts.n_last     = (CW'(n_r) == doc_len_r - CW'(1));
  assign sts.s_last     = (s_r == sweeps_r - 10'd1);
  assign sts.total_zero = (total_r == '0);
  assign sts.hit        = (ws_q_r > u_r);
  assign sts.div_done   = (bit_r == '0);

  assign out_topic       = 4'(k_r);
  assign out_theta_q0_16 = (den == '0) ? 17'd0 : q_r;
  assign out_last        = sts.k_last;

  // memories
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD && load_ok) begin
      phi_mem[PA'(in_topic_index) * VOC + PA'(in_term_id)] <= in_term_prob;
    end
    if (cmd == CMD_PHI) begin
      phi_q_r <= phi_mem[phi_addr];
    end
    if (cmd == CMD_APPEND && doc_len_r != CW'(MAX_DOC_WORDS)) begin
      word_mem[NW'(doc_len_r)] <= in_term_id;
      asg_mem[NW'(doc_len_r)]  <= app_topic;
    end
    if (cmd == CMD_READ) begin
      word_q_r <= word_mem[n_r];
      asg_q_r  <= asg_mem[n_r];
    end
    if (cmd == CMD_COMMIT) begin
      asg_mem[n_r] <= pick_r;
    end
    if (cmd == CMD_ACC) begin
      wsum_mem[k_r] <= tsum;
    end
    if (cmd == CMD_SRD) begin
      ws_q_r <= wsum_mem[k_r];
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      doc_len_r <= '0;
      alpha_r   <= ALPHA_RST;
      lfsr_r    <= SEED_RST;
      for (int i = 0; i < NUM_TOPICS; i++) cnt_r[i] <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_ALPHA) begin
          alpha_r <= cfg_data[15:0];
        end else begin
          lfsr_r <= (cfg_data == '0) ? 32'd1 : cfg_data;
        end
      end
      case (cmd)
        CMD_APPEND: begin
          if (doc_len_r != CW'(MAX_DOC_WORDS)) begin
            lfsr_r             <= lfsr_adv;
            cnt_r[app_topic]   <= cnt_r[app_topic] + CW'(1);
            doc_len_r          <= doc_len_r + CW'(1);
          end
        end
        CMD_REMOVE: begin
          if (cnt_r[asg_q_r] != '0) cnt_r[asg_q_r] <= cnt_r[asg_q_r] - CW'(1);
        end
        CMD_DRAW_LO: lfsr_r <= lfsr_adv;
        CMD_COMMIT:  cnt_r[pick_r] <= cnt_r[pick_r] + CW'(1);
        CMD_CLEAR: begin
          doc_len_r <= '0;
          for (int i = 0; i < NUM_TOPICS; i++) cnt_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // loop counters and arithmetic
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_START: begin
        sweeps_r <= in_sweep_count;
        s_r      <= '0;
        n_r      <= '0;
      end
      CMD_REMOVE: begin
        term_r    <= word_q_r;
        term_ok_r <= (32'(word_q_r) < VOCAB_SIZE);
        pick_r    <= asg_q_r;
        total_r   <= '0;
        k_r       <= '0;
      end
      CMD_MUL: w_r <= WW'(aval) * WW'(term_ok_r ? phi_q_r : 16'd0);
      CMD_ACC: begin
        total_r <= tsum;
        k_r     <= k_r + TW'(1);
      end
      CMD_DRAW_LO: begin
        r_r       <= lfsr_adv;
        lo_prod_r <= 64'(lfsr_adv) * 64'(total_r[31:0]);
      end
      CMD_DRAW_HI: hi_prod_r <= SW'(r_r) * SW'(total_r[SW-1:32]);
      CMD_DRAW_U: begin
        u_r <= hi_prod_r + SW'(lo_prod_r[63:32]);
        k_r <= '0;
      end
      CMD_SCMP: begin
        if (ws_q_r > u_r) pick_r <= k_r;
        k_r <= k_r + TW'(1);
      end
      CMD_COMMIT: begin
        if (sts.n_last) begin
          n_r <= '0;
          s_r <= s_r + 10'd1;
        end else begin
          n_r <= n_r + NW'(1);
        end
      end
      CMD_OUT_INIT: k_r <= '0;
      CMD_DIV_INIT: begin
        rem_r <= RW'(aval);
        q_r   <= '0;
        bit_r <= 5'd16;
      end
      CMD_DIV_STEP: begin
        // restoring divide, one quotient bit per cycle
        q_r   <= {q_r[15:0], ge};
        rem_r <= {rem_sub[RW-2:0], 1'b0};
        bit_r <= bit_r - 5'd1;
      end
      CMD_OUT_NEXT: k_r <= k_r + TW'(1);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0) else $error("lfsr reached zero");
  a_doc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(doc_len_r) <= MAX_DOC_WORDS) else $error("doc length overflow");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_CLEAR |=> doc_len_r == '0) else $error("document not cleared");
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_COMMIT |-> 32'(pick_r) < NUM_TOPICS) else $error("pick out of range");
`endif

endmodule

/* design/lda_gibbs_topic_inference.sv */
// A run resamples every word in each sweep through the per-topic phi read,
// multiply and accumulate loop and the topic draw, then gives each topic result
// from the bit-serial divider. One item is worked on at a time.
// Reset (synchronous): counts, doc length and control clear; alpha 26, LFSR 1;
// phi, word and topic stores are not cleared.
module lda_gibbs_topic_inference
  import lgti_pkg::*;
#(
  parameter int NUM_TOPICS    = NUM_TOPICS_DEF,
  parameter int VOCAB_SIZE    = VOCAB_SIZE_DEF,
  parameter int MAX_DOC_WORDS = MAX_DOC_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_topic_index,
  input  logic [9:0]  in_term_id,
  input  logic [15:0] in_term_prob,
  input  logic [9:0]  in_sweep_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_topic,
  output logic [16:0] out_theta_q0_16,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lgti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lgti_dp #(
    .NUM_TOPICS    (NUM_TOPICS),
    .VOCAB_SIZE    (VOCAB_SIZE),
    .MAX_DOC_WORDS (MAX_DOC_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_topic_index  (in_topic_index),
    .in_term_id      (in_term_id),
    .in_term_prob    (in_term_prob),
    .in_sweep_count  (in_sweep_count),
    .out_topic       (out_topic),
    .out_theta_q0_16 (out_theta_q0_16),
    .out_last        (out_last)
  );

endmodule

/* dv/lda_gibbs_topic_inference_tb.sv */
// Self-checking testbench for the LDA Gibbs topic inference block.
`timescale 1ns / 100ps

module lda_gibbs_topic_inference_tb;
  import lgti_pkg::*;

  localparam int K         = NUM_TOPICS_DEF;
  localparam int VOCAB     = VOCAB_SIZE_DEF;
  localparam int MAXW      = MAX_DOC_WORDS_DEF;
  localparam int CYC_LIMIT = 3000000;
  localparam int IDLE_WAIT = 64;
  localparam int ZERO_TERM = 7;   // every phi of this term is loaded as zero

  typedef struct packed {
    logic [3:0]  topic;
    logic [16:0] theta;
    logic        last;
  } theta_beat_t;

  typedef struct {
    op_t         op;
    logic [3:0]  topic;
    logic [9:0]  term;
    logic [15:0] prob;
    logic [9:0]  sweeps;
    bit          typed;
    logic [16:0] theta;
  } stim_row_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_op;
  logic [3:0]  in_topic_index;
  logic [9:0]  in_term_id;
  logic [15:0] in_term_prob;
  logic [9:0]  in_sweep_count;
  logic        out_valid, out_ready;
  logic [3:0]  out_topic;
  logic [16:0] out_theta_q0_16;
  logic        out_last;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;

  lda_gibbs_topic_inference u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_topic_index(in_topic_index), .in_term_id(in_term_id),
    .in_term_prob(in_term_prob), .in_sweep_count(in_sweep_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_topic(out_topic),
    .out_theta_q0_16(out_theta_q0_16), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] phi_mem [K][VOCAB];
  logic [9:0]  doc_terms [MAXW];
  logic [3:0]  doc_topics [MAXW];
  int unsigned topic_cnt [K];
  int unsigned doc_len;
  logic [31:0] rng;
  logic [15:0] alpha;

  theta_beat_t theta_q[$];
  int errors, n_items, n_beats, n_runs;
  int cycles;
  bit calm;          // no idling on either side while set
  int pool[8] = '{0, 1023, 512, 341, 682, ZERO_TERM, 900, 100};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, theta_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] rng_step(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    return s[0] ? (n ^ 32'h8020_0003) : n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one Gibbs resample of document word n
  task automatic resample_word(input int n);
    logic [3:0]  prev, pick;
    logic [9:0]  w;
    logic [63:0] total, u;
    logic [63:0] cum [K];
    logic [71:0] prod;
    bit          found;
    prev = doc_topics[n];
    w = doc_terms[n];
    pick = prev;
    found = 0;
    total = '0;
    if (topic_cnt[prev] > 0) topic_cnt[prev]--;
    for (int k = 0; k < K; k++) begin
      total += (64'(topic_cnt[k]) * 256 + 64'(alpha)) * 64'(phi_mem[k][w]);
      cum[k] = total;
    end
    rng = rng_step(rng);
    prod = 72'(rng) * 72'(total);
    u = 64'(prod >> 32);
    if (total != 0)
      for (int k = 0; k < K; k++)
        if (!found && cum[k] > u) begin
          pick = 4'(k);
          found = 1;
        end
    doc_topics[n] = pick;
    topic_cnt[pick]++;
  endtask

  task automatic gibbs_predict(input op_t op, input logic [3:0] topic, input logic [9:0] term,
                               input logic [15:0] prob, input logic [9:0] sweeps,
                               input bit keep);
    logic [63:0] num, den;
    theta_beat_t b;
    case (op)
      OP_LOAD: phi_mem[topic][term] = prob;
      OP_APPEND: begin
        if (doc_len < MAXW) begin
          rng = rng_step(rng);
          doc_terms[doc_len] = term;
          doc_topics[doc_len] = rng[31:28];
          topic_cnt[rng[31:28]]++;
          doc_len++;
        end
      end
      OP_RUN: begin
        for (int s = 0; s < sweeps; s++)
          for (int n = 0; n < doc_len; n++) resample_word(n);
        den = 64'(doc_len) * 256 + 64'(K) * 64'(alpha);
        for (int k = 0; k < K; k++) begin
          num = (64'(topic_cnt[k]) * 256 + 64'(alpha)) << 16;
          b.topic = 4'(k);
          b.theta = (den != 0) ? 17'(num / den) : '0;
          b.last = (k == K - 1);
          if (keep) theta_q.push_back(b);
          topic_cnt[k] = 0;
        end
        doc_len = 0;
        n_runs++;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input op_t op, input logic [3:0] topic, input logic [9:0] term,
                           input logic [15:0] prob, input logic [9:0] sweeps,
                           input bit keep = 1);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_topic_index <= topic;
    in_term_id <= term;
    in_term_prob <= prob;
    in_sweep_count <= sweeps;
    do @(posedge clk); while (!in_ready);
    gibbs_predict(op, topic, term, prob, sweeps, keep);
    n_items++;
  endtask

  // register writes only once the block has drained
  task automatic write_reg(input logic idx, input logic [31:0] data);
    in_valid <= 1'b0;
    wait (theta_q.size() == 0);
    @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ALPHA) alpha = data[15:0];
    else rng = (data == 0) ? 32'd1 : data;
  endtask

  // result side: random stalls, some long
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_left <= $urandom_range(10, 50);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk) begin
    theta_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      n_beats++;
      if (theta_q.size() == 0) begin
        $display("%0t: unexpected beat topic %0d theta %0d last %0b", $realtime,
                 out_topic, out_theta_q0_16, out_last);
        errors++;
      end else begin
        e = theta_q.pop_front();
        if (out_topic !== e.topic) begin
          $display("%0t: topic exp %0d got %0d", $realtime, e.topic, out_topic);
          errors++;
        end
        if (out_theta_q0_16 !== e.theta) begin
          $display("%0t: theta (topic %0d) exp %0d got %0d", $realtime, e.topic, e.theta,
                   out_theta_q0_16);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last (topic %0d) exp %0b got %0b", $realtime, e.topic, e.last,
                   out_last);
          errors++;
        end
      end
    end
  end

  task automatic push_flat(input logic [16:0] v);
    theta_beat_t b;
    for (int k = 0; k < K; k++) begin
      b.topic = 4'(k);
      b.theta = v;
      b.last = (k == K - 1);
      theta_q.push_back(b);
    end
  endtask

  stim_row_t rows[$];

  initial begin
    int r, t;
    logic [15:0] p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_topic_index = '0;
    in_term_id = '0;
    in_term_prob = '0;
    in_sweep_count = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_data = '0;
    cycles = 0;
    stall_left = 0;
    calm = 0;
    errors = 0;
    alpha = ALPHA_RST;
    rng = SEED_RST;
    doc_len = 0;
    for (int k = 0; k < K; k++) topic_cnt[k] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty document right after reset: every theta is 1/16
    rows.push_back('{OP_RUN, 4'd0, 10'd0, 16'd0, 10'd0, 1, 17'd4096});
    rows.push_back('{OP_NONE, 4'd15, 10'd1023, 16'hFFFF, 10'd1023, 0, 17'd0});
    // phi for the term pool; every appended term has all its rows written
    foreach (pool[i])
      for (int k = 0; k < K; k++) begin
        r = $urandom_range(0, 7);
        p = (pool[i] == ZERO_TERM) ? 16'd0 : (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
            16'($urandom);
        rows.push_back('{OP_LOAD, 4'(k), 10'(pool[i]), p, 10'd0, 0, 17'd0});
      end
    rows.push_back('{OP_LOAD, 4'd15, 10'd1023, 16'hFFFF, 10'd0, 0, 17'd0});
    rows.push_back('{OP_LOAD, 4'd0, 10'd0, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_APPEND, 4'd0, 10'd0, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_APPEND, 4'd0, 10'd1023, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_APPEND, 4'd0, 10'(ZERO_TERM), 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_RUN, 4'd0, 10'd0, 16'd0, 10'd1, 0, 17'd0});
    rows.push_back('{OP_APPEND, 4'd0, 10'd512, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_APPEND, 4'd0, 10'd341, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_RUN, 4'd0, 10'd0, 16'd0, 10'd1023, 0, 17'd0});
    rows.push_back('{OP_RUN, 4'd0, 10'd0, 16'd0, 10'd0, 1, 17'd4096});
    // zero weight everywhere: the word keeps its topic
    rows.push_back('{OP_APPEND, 4'd0, 10'(ZERO_TERM), 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_RUN, 4'd0, 10'd0, 16'd0, 10'd3, 0, 17'd0});
    rows.push_back('{OP_NONE, 4'd0, 10'd0, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_APPEND, 4'd0, 10'd100, 16'd0, 10'd0, 0, 17'd0});
    rows.push_back('{OP_RUN, 4'd0, 10'd0, 16'd0, 10'd2, 0, 17'd0});
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].topic, rows[i].term, rows[i].prob, rows[i].sweeps,
                !rows[i].typed);
      if (rows[i].typed) push_flat(rows[i].theta);
    end

    // alpha zero on an empty document: zero denominator
    write_reg(CFG_ALPHA, 32'd0);
    send_item(OP_RUN, 4'd0, 10'd0, 16'd0, 10'd0, 0);
    push_flat(17'd0);
    // alpha zero with one word: that topic takes all of it
    send_item(OP_APPEND, 4'd0, 10'd512, 16'd0, 10'd0);
    send_item(OP_RUN, 4'd0, 10'd0, 16'd0, 10'd4);

    // zero seed, full document with the extreme alpha
    write_reg(CFG_SEED, 32'd0);
    write_reg(CFG_ALPHA, 32'hFFFF);
    calm = 1;
    for (int i = 0; i <= MAXW; i++)
      send_item(OP_APPEND, 4'd0, 10'(pool[$urandom_range(0, 7)]), 16'd0, 10'd0);
    send_item(OP_APPEND, 4'd0, 10'd0, 16'd0, 10'd0);   // dropped
    send_item(OP_RUN, 4'd0, 10'd0, 16'd0, 10'd1);
    calm = 0;

    // random phases: mostly well-formed documents, some noise
    for (int ph = 0; ph < 5; ph++) begin
      r = $urandom_range(0, 3);
      write_reg(CFG_ALPHA, (r == 0) ? 32'd1 : (r == 1) ? 32'($urandom_range(1, 65535)) :
                32'($urandom_range(1, 512)));
      r = $urandom_range(0, 3);
      write_reg(CFG_SEED, (r == 0) ? 32'hFFFF_FFFF : $urandom);
      calm = (ph == 2);
      for (int i = 0; i < 22; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_item(OP_APPEND, 4'($urandom), 10'(pool[$urandom_range(0, 7)]), 16'($urandom),
                    10'($urandom));
        end else if (r < 75) begin
          t = pool[$urandom_range(0, 7)];
          if (t == ZERO_TERM) t = $urandom_range(0, VOCAB - 1);
          send_item(OP_LOAD, 4'($urandom), 10'(t), 16'($urandom), 10'($urandom));
        end else if (r < 92) begin
          send_item(OP_RUN, 4'($urandom), 10'($urandom),
                    16'($urandom), ($urandom_range(0, 9) == 0) ? 10'($urandom_range(20, 40)) :
                    10'($urandom_range(0, 5)));
        end else begin
          send_item(OP_NONE, 4'($urandom), 10'($urandom), 16'($urandom), 10'($urandom));
        end
      end
      send_item(OP_RUN, 4'd0, 10'd0, 16'd0, 10'($urandom_range(1, 4)));
    end
    in_valid <= 1'b0;
    calm = 0;

    wait (theta_q.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk);
    if (theta_q.size() != 0) begin
      $display("%0d expected beats never arrived", theta_q.size());
      errors++;
    end
    $display("covered %0d items and %0d runs, %0d result beats checked", n_items, n_runs,
             n_beats);
    $display("alpha 0/1/65535, seeds 0/1/all ones, full document, zero-weight words");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

/* lda_gibbs_topic_inference.f */
design/lgti_pkg.sv
design/lgti_ctrl.sv
design/lgti_dp.sv
design/lda_gibbs_topic_inference.sv
dv/lda_gibbs_topic_inference_tb.sv
